@@ src/cbm_pkg.sv @@
`timescale 1ns / 1ps

package cbm_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_PRG   = 2'd2,
    OP_CHR   = 2'd3
  } op_e;

  // One input item as held in the input register
  typedef struct packed {
    op_e         op;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cycles;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] bank;
    logic       irq;
    logic [1:0] mirroring;
  } result_t;

  // Number of 1K CHR bank slots
  localparam int CHR_SLOTS_DEF = 8;

  // Configuration register indexes
  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  // CPU write pages, top nibble of the address
  localparam logic [3:0] PAGE_PRG0 = 4'h8;
  localparam logic [3:0] PAGE_CTRL = 4'h9;
  localparam logic [3:0] PAGE_PRG1 = 4'hA;
  localparam logic [3:0] PAGE_CHR  = 4'hB;

  // Control registers in the 0x9000 page, low three address bits
  localparam logic [2:0] REG_PRG_MODE = 3'd0;
  localparam logic [2:0] REG_MIRROR   = 3'd1;
  localparam logic [2:0] REG_IRQ_EN   = 3'd3;
  localparam logic [2:0] REG_IRQ_LOAD = 3'd4;
  localparam logic [2:0] REG_LATCH_HI = 3'd5;
  localparam logic [2:0] REG_LATCH_LO = 3'd6;

  // Mirroring codes on the result
  localparam logic [1:0] MIR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;

  // Fixed PRG banks
  localparam logic [7:0] BANK_SECOND_LAST = 8'hFE;
  localparam logic [7:0] BANK_LAST        = 8'hFF;

endpackage

@@ src/cbm_core.sv @@
`timescale 1ns / 1ps

module cbm_core #(
  parameter int CHR_SLOTS = cbm_pkg::CHR_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cbm_pkg::item_t  item_i,
  input  logic [7:0]      prg_mask_i,
  input  logic [7:0]      chr_mask_i,
  output cbm_pkg::result_t res_o
);
  import cbm_pkg::*;

  localparam int ChrIdxW = $clog2(CHR_SLOTS);

  logic [7:0]  prg_banks_q [2];
  logic [7:0]  prg_banks_d [2];
  logic [7:0]  chr_banks_q [CHR_SLOTS];
  logic [7:0]  chr_banks_d [CHR_SLOTS];
  logic        swap_q, swap_d;
  logic [1:0]  mirror_q, mirror_d;
  logic        irq_en_q, irq_en_d;
  logic        irq_pend_q, irq_pend_d;
  logic [15:0] irq_cnt_q, irq_cnt_d;
  logic [15:0] irq_rld_q, irq_rld_d;
  logic [15:0] cnt_sub;
  logic [7:0]  raw_prg;
  logic [7:0]  bank;

  assign cnt_sub = irq_cnt_q - {8'd0, item_i.cycles};

  // Next state for the item being processed
  always_comb begin
    prg_banks_d = prg_banks_q;
    chr_banks_d = chr_banks_q;
    swap_d      = swap_q;
    mirror_d    = mirror_q;
    irq_en_d    = irq_en_q;
    irq_pend_d  = irq_pend_q;
    irq_cnt_d   = irq_cnt_q;
    irq_rld_d   = irq_rld_q;
    if (en_i) begin
      unique case (item_i.op)
        OP_WRITE: begin
          unique case (item_i.address[15:12])
            PAGE_PRG0, PAGE_PRG1: begin
              prg_banks_d[item_i.address[13]] = item_i.write_data;
            end
            PAGE_CTRL: begin
              unique case (item_i.address[2:0])
                REG_PRG_MODE: swap_d = item_i.write_data[7];
                REG_MIRROR:   mirror_d = item_i.write_data[7:6];
                REG_IRQ_EN: begin
                  irq_en_d   = item_i.write_data[7];
                  irq_pend_d = 1'b0;
                end
                REG_IRQ_LOAD: begin
                  irq_cnt_d  = irq_rld_q;
                  irq_pend_d = 1'b0;
                end
                REG_LATCH_HI: irq_rld_d[15:8] = item_i.write_data;
                REG_LATCH_LO: irq_rld_d[7:0] = item_i.write_data;
                default: ;
              endcase
            end
            PAGE_CHR: begin
              chr_banks_d[item_i.address[ChrIdxW-1:0]] = item_i.write_data;
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          // Count down while enabled; fire at zero or below as signed.
          if (irq_en_q) begin
            irq_cnt_d = cnt_sub;
            if (cnt_sub == 16'd0 || cnt_sub[15]) begin
              irq_pend_d = 1'b1;
              irq_en_d   = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // PRG slot layout
  always_comb begin
    unique case (item_i.address[14:13])
      2'd0:    raw_prg = swap_q ? BANK_SECOND_LAST : prg_banks_q[0];
      2'd1:    raw_prg = prg_banks_q[1];
      2'd2:    raw_prg = swap_q ? prg_banks_q[0] : BANK_SECOND_LAST;
      default: raw_prg = BANK_LAST;
    endcase
  end

  // Translated bank for the result
  always_comb begin
    bank = 8'd0;
    unique case (item_i.op)
      OP_PRG: begin
        if (item_i.address[15]) begin
          bank = raw_prg & prg_mask_i;
        end
      end
      OP_CHR: begin
        if (item_i.address[15:13] == 3'd0) begin
          bank = chr_banks_q[item_i.address[10 +: ChrIdxW]] & chr_mask_i;
        end
      end
      default: bank = 8'd0;
    endcase
  end

  // Result reports the state after the item
  always_comb begin
    res_o.bank = bank;
    res_o.irq  = irq_pend_d;
    unique case (mirror_d)
      2'b00:   res_o.mirroring = MIR_VERTICAL;
      2'b10:   res_o.mirroring = MIR_HORIZONTAL;
      default: res_o.mirroring = MIR_SINGLE_LO;
    endcase
  end

  // Mapper state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q[0] <= 8'd0;
      prg_banks_q[1] <= 8'd1;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_banks_q[i] <= 8'(i);
      end
      swap_q     <= 1'b0;
      mirror_q   <= 2'd0;
      irq_en_q   <= 1'b0;
      irq_pend_q <= 1'b0;
      irq_cnt_q  <= 16'd0;
      irq_rld_q  <= 16'd0;
    end else begin
      prg_banks_q <= prg_banks_d;
      chr_banks_q <= chr_banks_d;
      swap_q      <= swap_d;
      mirror_q    <= mirror_d;
      irq_en_q    <= irq_en_d;
      irq_pend_q  <= irq_pend_d;
      irq_cnt_q   <= irq_cnt_d;
      irq_rld_q   <= irq_rld_d;
    end
  end

endmodule

@@ src/cartridge_bank_mapper_with_irq.sv @@
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | op, address, write_data, cycles
// out     | output    | out_valid_o/out_stall_i | bank, irq, mirroring
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item is accepted every clock while in_stall_o is low; each item is registered in the
// input register and its result in the result register.
// Reset restores the bank registers and clears the IRQ logic; the masks read 0xFF.
// A stalled result holds; the input register keeps taking items while it is empty or the
// result register is free or being taken, so once both registers are full a stall on the
// result reaches the input in the same cycle.
module cartridge_bank_mapper_with_irq #(
  parameter int CHR_SLOTS = cbm_pkg::CHR_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  cycles_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  bank_o,
  output logic        irq_o,
  output logic [1:0]  mirroring_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import cbm_pkg::*;

  logic       in_valid_q;
  item_t      item_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res;
  logic [7:0] prg_mask_q;
  logic [7:0] chr_mask_q;
  logic       out_free;
  logic       advance;

  // The result register frees when empty or when its transfer completes.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  // Configuration masks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_mask_q <= 8'hFF;
      chr_mask_q <= 8'hFF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRG_MASK: prg_mask_q <= cfg_data_i;
        CFG_CHR_MASK: chr_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid flags of the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.op         <= op_e'(op_i);
      item_q.address    <= address_i;
      item_q.write_data <= write_data_i;
      item_q.cycles     <= cycles_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  cbm_core #(
    .CHR_SLOTS (CHR_SLOTS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .item_i     (item_q),
    .prg_mask_i (prg_mask_q),
    .chr_mask_i (chr_mask_q),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign bank_o      = res_q.bank;
  assign irq_o       = res_q.irq;
  assign mirroring_o = res_q.mirroring;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cbm_pkg::*;

  // Cycles without any transfer before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 330;
  localparam int PHASES = 6;
  localparam int HOLD_CYCLES = 60;

  // Mirroring select bits as written by the CPU
  localparam logic [1:0] MSEL_VERTICAL   = 2'd0;
  localparam logic [1:0] MSEL_HORIZONTAL = 2'd2;

  // 8K PRG windows, address bits 14:13 inside the upper half
  localparam logic [1:0] SLOT_8000 = 2'd0;
  localparam logic [1:0] SLOT_A000 = 2'd1;
  localparam logic [1:0] SLOT_C000 = 2'd2;

  // Mapper state mirrored in software, with the results still owed by the block.
  class mapper_scoreboard;
    logic [7:0]  prg_mask;
    logic [7:0]  chr_mask;
    logic [7:0]  prg_bank [2];
    logic [7:0]  chr_bank [CHR_SLOTS_DEF];
    logic        swap_mode;
    logic [1:0]  mirror_sel;
    logic        irq_armed;
    logic        irq_line;
    logic [15:0] irq_count;
    logic [15:0] irq_latch;
    result_t     expected_results [$];
    int          errors;

    function new();
      prg_mask = 8'hFF;
      chr_mask = 8'hFF;
      prg_bank[0] = 8'd0;
      prg_bank[1] = 8'd1;
      for (int i = 0; i < CHR_SLOTS_DEF; i++) chr_bank[i] = 8'(i);
      swap_mode = 1'b0;
      mirror_sel = MSEL_VERTICAL;
      irq_armed = 1'b0;
      irq_line = 1'b0;
      irq_count = 16'd0;
      irq_latch = 16'd0;
      errors = 0;
    endfunction

    function void set_mask(input logic idx, input logic [7:0] value);
      if (idx == CFG_PRG_MASK) prg_mask = value;
      else chr_mask = value;
    endfunction

    // Applies one access to the state and returns what the block should report.
    function result_t apply_access(input item_t it);
      result_t    r;
      logic [7:0] raw;
      r = '0;
      case (it.op)
        OP_WRITE: begin
          case (it.address[15:12])
            PAGE_PRG0, PAGE_PRG1: prg_bank[it.address[13]] = it.write_data;
            PAGE_CTRL: begin
              case (it.address[2:0])
                REG_PRG_MODE: swap_mode = it.write_data[7];
                REG_MIRROR:   mirror_sel = it.write_data[7:6];
                REG_IRQ_EN: begin
                  irq_armed = it.write_data[7];
                  irq_line = 1'b0;
                end
                REG_IRQ_LOAD: begin
                  irq_count = irq_latch;
                  irq_line = 1'b0;
                end
                REG_LATCH_HI: irq_latch[15:8] = it.write_data;
                REG_LATCH_LO: irq_latch[7:0] = it.write_data;
                default: ;
              endcase
            end
            PAGE_CHR: chr_bank[it.address[2:0]] = it.write_data;
            default: ;
          endcase
        end
        OP_TICK: begin
          // The counter wraps in 16 bits; zero or a negative value fires the IRQ.
          if (irq_armed) begin
            irq_count = irq_count - 16'(it.cycles);
            if (irq_count == 16'd0 || irq_count[15]) begin
              irq_line = 1'b1;
              irq_armed = 1'b0;
            end
          end
        end
        OP_PRG: begin
          if (it.address[15]) begin
            case (it.address[14:13])
              SLOT_8000: raw = swap_mode ? BANK_SECOND_LAST : prg_bank[0];
              SLOT_A000: raw = prg_bank[1];
              SLOT_C000: raw = swap_mode ? prg_bank[0] : BANK_SECOND_LAST;
              default:   raw = BANK_LAST;
            endcase
            r.bank = raw & prg_mask;
          end
        end
        default: begin
          if (it.address < 16'h2000) r.bank = chr_bank[it.address[12:10]] & chr_mask;
        end
      endcase
      r.irq = irq_line;
      if (mirror_sel == MSEL_VERTICAL) r.mirroring = MIR_VERTICAL;
      else if (mirror_sel == MSEL_HORIZONTAL) r.mirroring = MIR_HORIZONTAL;
      else r.mirroring = MIR_SINGLE_LO;
      return r;
    endfunction

    function void note_access(input item_t it);
      expected_results.push_back(apply_access(it));
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, bank %0d irq %0d mirroring %0d", $time,
                 got.bank, got.irq, got.mirroring);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.bank !== want.bank) begin
        $display("%0t: bank mismatch, expected %0d, actual %0d", $time, want.bank, got.bank);
        errors++;
      end
      if (got.irq !== want.irq) begin
        $display("%0t: irq mismatch, expected %0d, actual %0d", $time, want.irq, got.irq);
        errors++;
      end
      if (got.mirroring !== want.mirroring) begin
        $display("%0t: mirroring mismatch, expected %0d, actual %0d", $time,
                 want.mirroring, got.mirroring);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OP_WRITE;
  logic [15:0] address_i = 16'd0;
  logic [7:0]  write_data_i = 8'd0;
  logic [7:0]  cycles_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  bank_o;
  logic        irq_o;
  logic [1:0]  mirroring_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_PRG_MASK;
  logic [7:0]  cfg_data_i = 8'd0;

  mapper_scoreboard sb;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  logic idle_on = 1'b1;
  logic stall_on = 1'b1;
  logic hold_req = 1'b0;

  cartridge_bank_mapper_with_irq uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cycles_i     (cycles_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bank_o       (bank_o),
    .irq_o        (irq_o),
    .mirroring_o  (mirroring_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial forever #4 clk_i = ~clk_i;

  // Offers one item, with an occasional gap first, and returns once it is transferred.
  task automatic send_item(input item_t it);
    if (idle_on && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= it.op;
    address_i <= it.address;
    write_data_i <= it.write_data;
    cycles_i <= it.cycles;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_op(input op_e op, input logic [15:0] addr, input logic [7:0] data,
                         input logic [7:0] cyc);
    item_t it;
    it.op = op;
    it.address = addr;
    it.write_data = data;
    it.cycles = cyc;
    send_item(it);
  endtask

  // Both mask registers are written back to back while the block is idle.
  task automatic write_masks(input logic [7:0] prg_value, input logic [7:0] chr_value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_PRG_MASK;
    cfg_data_i <= prg_value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_mask(CFG_PRG_MASK, prg_value);
    cfg_index_i <= CFG_CHR_MASK;
    cfg_data_i <= chr_value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_mask(CFG_CHR_MASK, chr_value);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Any kind of access, biased towards the decoded windows.
  function automatic item_t random_access();
    item_t it;
    it.op = op_e'($urandom_range(0, 3));
    it.address = 16'($urandom());
    it.write_data = 8'($urandom());
    it.cycles = 8'($urandom());
    if (it.op == OP_WRITE && $urandom_range(0, 9) != 0)
      it.address[15:12] = 4'($urandom_range(PAGE_PRG0, PAGE_CHR));
    if (it.op == OP_PRG && $urandom_range(0, 3) != 0) it.address[15] = 1'b1;
    if (it.op == OP_CHR && $urandom_range(0, 3) != 0) it.address[15:13] = 3'b000;
    return it;
  endfunction

  // Latch, reload and enable the counter, then tick it down until it is likely to fire.
  task automatic irq_sequence();
    int ticks;
    ticks = $urandom_range(2, 10);
    send_op(OP_WRITE, {PAGE_CTRL, 9'($urandom()), REG_LATCH_HI}, 8'($urandom_range(0, 2)),
            8'($urandom()));
    send_op(OP_WRITE, {PAGE_CTRL, 9'($urandom()), REG_LATCH_LO}, 8'($urandom()),
            8'($urandom()));
    send_op(OP_WRITE, {PAGE_CTRL, 9'($urandom()), REG_IRQ_LOAD}, 8'($urandom()),
            8'($urandom()));
    send_op(OP_WRITE, {PAGE_CTRL, 9'($urandom()), REG_IRQ_EN}, {1'b1, 7'($urandom())},
            8'($urandom()));
    repeat (ticks) begin
      if ($urandom_range(0, 4) == 0) send_item(random_access());
      else send_op(OP_TICK, 16'($urandom()), 8'($urandom()), 8'($urandom()));
    end
    if ($urandom_range(0, 1) == 1)
      send_op(OP_WRITE, {PAGE_CTRL, 9'($urandom()), REG_IRQ_EN}, 8'($urandom()),
              8'($urandom()));
  endtask

  task automatic random_phase(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(0, 3) == 0) irq_sequence();
      else send_item(random_access());
    end
  endtask

  // Window edges, layout swap, mirroring, ignored writes and the counter corner cases.
  task automatic directed_items();
    send_op(OP_PRG, 16'h7FFF, 8'hFF, 8'hFF);
    send_op(OP_PRG, 16'h8000, 8'h00, 8'h00);
    send_op(OP_PRG, 16'hC000, 8'h00, 8'h00);
    send_op(OP_PRG, 16'hFFFF, 8'h00, 8'h00);
    send_op(OP_CHR, 16'h1FFF, 8'h00, 8'h00);
    send_op(OP_CHR, 16'h2000, 8'h00, 8'h00);
    send_op(OP_WRITE, 16'h8000, 8'hFF, 8'h00);
    send_op(OP_WRITE, 16'hA000, 8'h00, 8'h00);
    send_op(OP_WRITE, 16'h9000, 8'h80, 8'h00);
    send_op(OP_PRG, 16'h8000, 8'h00, 8'h00);
    send_op(OP_PRG, 16'hDFFF, 8'h00, 8'h00);
    send_op(OP_WRITE, 16'h9001, 8'h40, 8'h00);
    send_op(OP_WRITE, 16'h9001, 8'hC0, 8'h00);
    send_op(OP_WRITE, 16'h9001, 8'h80, 8'h00);
    send_op(OP_WRITE, 16'h9002, 8'hFF, 8'h00);
    send_op(OP_WRITE, 16'h9007, 8'hFF, 8'h00);
    send_op(OP_WRITE, 16'hC000, 8'hFF, 8'h00);
    send_op(OP_WRITE, 16'hB007, 8'hFF, 8'h00);
    send_op(OP_CHR, 16'h1C00, 8'h00, 8'h00);
    // Counter reaches exactly zero, then a zero-cycle tick on a zero count fires again.
    send_op(OP_WRITE, 16'h9006, 8'h03, 8'h00);
    send_op(OP_WRITE, 16'h9004, 8'h00, 8'h00);
    send_op(OP_WRITE, 16'h9003, 8'h80, 8'h00);
    send_op(OP_TICK, 16'h0000, 8'h00, 8'h03);
    send_op(OP_WRITE, 16'h9003, 8'h80, 8'h00);
    send_op(OP_TICK, 16'h0000, 8'h00, 8'h00);
    // A large tick drives the count negative; further ticks are ignored once disarmed.
    send_op(OP_WRITE, 16'h9004, 8'h00, 8'h00);
    send_op(OP_WRITE, 16'h9003, 8'h80, 8'h00);
    send_op(OP_TICK, 16'hFFFF, 8'h00, 8'hFF);
    send_op(OP_TICK, 16'h0000, 8'h00, 8'h05);
    send_op(OP_WRITE, 16'h9003, 8'h00, 8'h00);
  endtask

  // Receiver: occasional random stalls, and one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= stall_on && ($urandom_range(0, 99) < 10);
    end
  end

  // Records every transfer on both channels and watches for a stuck block.
  always @(posedge clk_i) begin : monitor
    item_t   seen;
    result_t got;
    logic    moved;
    moved = 1'b0;
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        seen.op = op_e'(op_i);
        seen.address = address_i;
        seen.write_data = write_data_i;
        seen.cycles = cycles_i;
        sb.note_access(seen);
        moved = 1'b1;
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        got.bank = bank_o;
        got.irq = irq_o;
        got.mirroring = mirroring_o;
        sb.check_result(got);
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o === 1'b1) moved = 1'b1;
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Reset, then a directed pass and several random phases with different masks.
  initial begin
    sb = new();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_masks(8'hFF, 8'hFF);
    directed_items();
    drain();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_masks(8'h00, 8'h00);
        1: write_masks(8'h0F, 8'h07);
        2: write_masks(8'hFF, 8'h00);
        3: write_masks(8'h3F, 8'h1F);
        4: write_masks(8'h00, 8'hFF);
        default: write_masks(8'($urandom()), 8'($urandom()));
      endcase
      idle_on = (p != 3);
      stall_on = (p != 3);
      if (p == 1) hold_req = 1'b1;
      random_phase(ITEMS_PER_PHASE);
      drain();
    end
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/cbm_pkg.sv
src/cbm_core.sv
src/cartridge_bank_mapper_with_irq.sv
tb/sv/tb_top.sv
